>>> src/elr_pkg.sv
// elr_pkg: types, codes and sizes shared by the error log ring
// no dependencies; imported by elr_status, the top and the testbench
`default_nettype none

package elr_pkg;

    localparam int LOG_DEPTH = 8;
    localparam int ADDR_W    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int COUNT_W   = $clog2(LOG_DEPTH + 1);
    localparam int SUM_W     = ADDR_W + 1;
    localparam int CMP_W     = (COUNT_W > 8) ? COUNT_W + 1 : 9;

    localparam logic [1:0] MODE_LOG   = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    typedef struct packed {
        logic [31:0] stamp;
        logic [7:0]  code;
        logic [7:0]  channel;
        logic [7:0]  extra;
    } entry_t;

    typedef struct packed {
        logic        log_en;
        logic        clear_en;
        logic [31:0] stamp;
        logic [7:0]  code;
    } status_cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  head;
        logic [COUNT_W-1:0] count;
        logic [31:0]        total;
        logic [7:0]         newest_code;
        logic [31:0]        newest_stamp;
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_FETCH
    } ctrl_state_t;

endpackage

`default_nettype wire

>>> src/elr_in_if.sv
// elr_in_if: request channel of the error log ring, valid/ready plus item fields
// no dependencies
`default_nettype none

interface elr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] stamp;
    logic [7:0]  error_code;
    logic [7:0]  channel_id;
    logic [7:0]  extra_byte;
    logic [7:0]  age_index;

    modport source (
        output valid, mode, stamp, error_code, channel_id, extra_byte, age_index,
        input  ready
    );
    modport sink (
        input  valid, mode, stamp, error_code, channel_id, extra_byte, age_index,
        output ready
    );
endinterface

`default_nettype wire

>>> src/elr_out_if.sv
// elr_out_if: response channel of the error log ring, valid/ready plus result fields
// no dependencies
`default_nettype none

interface elr_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] read_stamp;
    logic [7:0]  read_code;
    logic [7:0]  read_channel;
    logic [7:0]  read_extra;
    logic [3:0]  valid_count;
    logic [7:0]  newest_code;
    logic [31:0] newest_stamp;
    logic [31:0] lifetime_total;

    modport source (
        output valid, found, read_stamp, read_code, read_channel, read_extra,
               valid_count, newest_code, newest_stamp, lifetime_total,
        input  ready
    );
    modport sink (
        input  valid, found, read_stamp, read_code, read_channel, read_extra,
               valid_count, newest_code, newest_stamp, lifetime_total,
        output ready
    );
endinterface

`default_nettype wire

>>> src/elr_ram.sv
// elr_ram: generic single-write, single-read synchronous ram, registered read
// no dependencies
`default_nettype none

module elr_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> src/elr_status.sv
// elr_status: write head, saturating count, lifetime total and newest entry copy
// depends on elr_pkg
`default_nettype none

module elr_status
    import elr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire status_cmd_t cmd,
    output status_t          status
);

    logic [ADDR_W-1:0]  head_reg,  head_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [31:0]        total_reg, total_next;
    logic [7:0]         newest_code_reg,  newest_code_next;
    logic [31:0]        newest_stamp_reg, newest_stamp_next;
    logic [SUM_W-1:0]   head_inc;

    always_comb
    begin
        head_inc          = SUM_W'(head_reg) + SUM_W'(1);
        head_next         = head_reg;
        count_next        = count_reg;
        total_next        = total_reg;
        newest_code_next  = newest_code_reg;
        newest_stamp_next = newest_stamp_reg;
        if (cmd.log_en)
        begin
            head_next = (head_inc == SUM_W'(LOG_DEPTH)) ? '0 : head_inc[ADDR_W-1:0];
            if (count_reg != COUNT_W'(LOG_DEPTH))
            begin
                count_next = count_reg + COUNT_W'(1);
            end
            total_next        = total_reg + 32'd1;
            newest_code_next  = cmd.code;
            newest_stamp_next = cmd.stamp;
        end
        else if (cmd.clear_en)
        begin
            head_next  = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        newest_code_reg  <= newest_code_next;
        newest_stamp_reg <= newest_stamp_next;
    end

    assign status.head         = head_reg;
    assign status.count        = count_reg;
    assign status.total        = total_reg;
    assign status.newest_code  = newest_code_reg;
    assign status.newest_stamp = newest_stamp_reg;

endmodule

`default_nettype wire

>>> src/overwriting_error_log_ring_top.sv
// overwriting_error_log_ring_top: control, entry ram and response register
// depends on elr_pkg, elr_in_if, elr_out_if, elr_ram, elr_status
//
// Error log of LOG_DEPTH entries kept in a synchronous ram; when full, a new
// log transaction overwrites the oldest entry. Each request passes through the
// idle and fetch states: the accept cycle issues the ram access and updates the
// counters, the next cycle loads the response register from the registered ram
// read data and the updated status. A new request is taken in the idle state as
// soon as the response register is free or being emptied, never while the
// previous one is still in the fetch state. Entries never written read back as
// undefined data, but no valid age index can reach them.
`default_nettype none

module overwriting_error_log_ring_top
    import elr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    elr_in_if.sink    req,
    elr_out_if.source rsp
);

    ctrl_state_t state_reg, state_next;
    logic        accept;
    logic        load_rsp;
    logic        rsp_free;

    status_cmd_t cmd;
    status_t     status;

    logic [SUM_W-1:0]  pos_sum;
    logic [ADDR_W-1:0] rd_pos;
    logic              hit;
    logic              found_reg, found_next;
    entry_t            wr_entry;
    entry_t            rd_entry;

    logic              rsp_valid_reg, rsp_valid_next;
    logic              rsp_found_reg;
    entry_t            rsp_entry_reg;
    logic [3:0]        rsp_count_reg;
    logic [7:0]        rsp_newest_code_reg;
    logic [31:0]       rsp_newest_stamp_reg;
    logic [31:0]       rsp_total_reg;

    assign rsp_free = !rsp_valid_reg || rsp.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid && rsp_free)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        req.ready = 1'b0;
        load_rsp  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = rsp_free;
            end
            ST_FETCH:
            begin
                load_rsp = 1'b1;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    assign accept = req.valid && req.ready;

    assign cmd.log_en   = accept && (req.mode == MODE_LOG);
    assign cmd.clear_en = accept && (req.mode == MODE_CLEAR);
    assign cmd.stamp    = req.stamp;
    assign cmd.code     = req.error_code;

    elr_status u_status (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status)
    );

    // age to slot, oldest entry sits at the head once the ring has wrapped
    always_comb
    begin
        hit     = CMP_W'(req.age_index) < CMP_W'(status.count);
        pos_sum = SUM_W'(status.head) + SUM_W'(req.age_index[ADDR_W-1:0]);
        if (status.count != COUNT_W'(LOG_DEPTH))
        begin
            rd_pos = req.age_index[ADDR_W-1:0];
        end
        else if (pos_sum >= SUM_W'(LOG_DEPTH))
        begin
            rd_pos = ADDR_W'(pos_sum - SUM_W'(LOG_DEPTH));
        end
        else
        begin
            rd_pos = pos_sum[ADDR_W-1:0];
        end
    end

    assign wr_entry.stamp   = req.stamp;
    assign wr_entry.code    = req.error_code;
    assign wr_entry.channel = req.channel_id;
    assign wr_entry.extra   = req.extra_byte;

    elr_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (LOG_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.log_en),
        .waddr (status.head),
        .wdata (wr_entry),
        .re    (accept && (req.mode == MODE_READ)),
        .raddr (rd_pos),
        .rdata (rd_entry)
    );

    assign found_next = accept ? (req.mode == MODE_READ) && hit : found_reg;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_rsp)
        begin
            rsp_found_reg <= found_reg;
            rsp_entry_reg <= found_reg ? rd_entry : '0;
            rsp_count_reg <= 4'(status.count);
            rsp_total_reg <= status.total;
            if (status.count == '0)
            begin
                rsp_newest_code_reg  <= 8'd0;
                rsp_newest_stamp_reg <= 32'd0;
            end
            else
            begin
                rsp_newest_code_reg  <= status.newest_code;
                rsp_newest_stamp_reg <= status.newest_stamp;
            end
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.found          = rsp_found_reg;
    assign rsp.read_stamp     = rsp_entry_reg.stamp;
    assign rsp.read_code      = rsp_entry_reg.code;
    assign rsp.read_channel   = rsp_entry_reg.channel;
    assign rsp.read_extra     = rsp_entry_reg.extra;
    assign rsp.valid_count    = rsp_count_reg;
    assign rsp.newest_code    = rsp_newest_code_reg;
    assign rsp.newest_stamp   = rsp_newest_stamp_reg;
    assign rsp.lifetime_total = rsp_total_reg;

endmodule

`default_nettype wire

>>> test/overwriting_error_log_ring_top_test.sv
// testbench for overwriting_error_log_ring_top: directed table then bursty random traffic
// depends on elr_pkg, elr_in_if, elr_out_if and the block itself; each response is checked
// field by field against a behavioural log in this file or a directed row's typed result
`default_nettype none

module overwriting_error_log_ring_top_test
    import elr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 600;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 40;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] stamp;
        logic [7:0]  code;
        logic [7:0]  chan;
        logic [7:0]  extra;
        logic [7:0]  age;
    } log_req_t;

    typedef struct packed {
        logic        found;
        logic [31:0] read_stamp;
        logic [7:0]  read_code;
        logic [7:0]  read_channel;
        logic [7:0]  read_extra;
        logic [3:0]  valid_count;
        logic [7:0]  newest_code;
        logic [31:0] newest_stamp;
        logic [31:0] lifetime_total;
    } log_result_t;

    typedef struct {
        log_req_t    req;
        bit          typed;
        log_result_t res;
    } table_row_t;

    logic clk;
    logic rst_n;

    elr_in_if  req_if ();
    elr_out_if rsp_if ();

    overwriting_error_log_ring_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // behavioural copy of the log
    entry_t      ring_slots [LOG_DEPTH];
    int          ring_head;
    int          ring_count;
    logic [31:0] ring_total;

    log_result_t pending_results [$];
    table_row_t  directed_rows [$];

    int          error_count;
    int          cycle_count;
    int          rsp_count;
    int          n_log, n_read, n_hit, n_clear, n_unused;
    bit          valid_held;
    int          burst_left;
    int          stall_style;
    int          rcv_cycle;
    log_result_t rsp_got;
    log_result_t rsp_want;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d responses outstanding",
                 cycle_count, pending_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic log_result_t predict_log_step(log_req_t r);
        log_result_t res;
        int pos;
        int newest;
        res = '0;
        case (r.mode)
            MODE_LOG:
            begin
                ring_slots[ring_head] = {r.stamp, r.code, r.chan, r.extra};
                ring_head = (ring_head + 1) % LOG_DEPTH;
                if (ring_count < LOG_DEPTH)
                    ring_count++;
                ring_total = ring_total + 32'd1;
            end
            MODE_READ:
            begin
                if (int'(r.age) < ring_count)
                begin
                    pos = (ring_count < LOG_DEPTH) ? int'(r.age)
                                                   : (ring_head + int'(r.age)) % LOG_DEPTH;
                    res.found        = 1'b1;
                    res.read_stamp   = ring_slots[pos].stamp;
                    res.read_code    = ring_slots[pos].code;
                    res.read_channel = ring_slots[pos].channel;
                    res.read_extra   = ring_slots[pos].extra;
                end
            end
            MODE_CLEAR:
            begin
                ring_head  = 0;
                ring_count = 0;
            end
            default:
            begin
            end
        endcase
        res.valid_count = 4'(ring_count);
        if (ring_count != 0)
        begin
            newest = (ring_head == 0) ? LOG_DEPTH - 1 : ring_head - 1;
            res.newest_code  = ring_slots[newest].code;
            res.newest_stamp = ring_slots[newest].stamp;
        end
        res.lifetime_total = ring_total;
        return res;
    endfunction

    function automatic log_req_t mk_req(logic [1:0] mode, logic [31:0] stamp, logic [7:0] code,
                                        logic [7:0] chan, logic [7:0] extra, logic [7:0] age);
        return {mode, stamp, code, chan, extra, age};
    endfunction

    function automatic log_result_t mk_res(logic found, logic [31:0] rs, logic [7:0] rc,
                                           logic [7:0] rch, logic [7:0] rx, logic [3:0] cnt,
                                           logic [7:0] nc, logic [31:0] ns, logic [31:0] tot);
        return {found, rs, rc, rch, rx, cnt, nc, ns, tot};
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (error_count < PRINT_LIMIT)
            $display("mismatch on response %0d, %s: got %h want %h", rsp_count, what, got, want);
        error_count++;
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // response side: check then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("response with nothing pending", 32'd0, 32'd0);
            end
            else
            begin
                rsp_want = pending_results.pop_front();
                rsp_got  = {rsp_if.found, rsp_if.read_stamp, rsp_if.read_code,
                            rsp_if.read_channel, rsp_if.read_extra, rsp_if.valid_count,
                            rsp_if.newest_code, rsp_if.newest_stamp, rsp_if.lifetime_total};
                check_field("found", rsp_got.found, rsp_want.found);
                check_field("read_stamp", rsp_got.read_stamp, rsp_want.read_stamp);
                check_field("read_code", rsp_got.read_code, rsp_want.read_code);
                check_field("read_channel", rsp_got.read_channel, rsp_want.read_channel);
                check_field("read_extra", rsp_got.read_extra, rsp_want.read_extra);
                check_field("valid_count", rsp_got.valid_count, rsp_want.valid_count);
                check_field("newest_code", rsp_got.newest_code, rsp_want.newest_code);
                check_field("newest_stamp", rsp_got.newest_stamp, rsp_want.newest_stamp);
                check_field("lifetime_total", rsp_got.lifetime_total, rsp_want.lifetime_total);
            end
            rsp_count++;
        end
        rcv_cycle++;
        if (rcv_cycle % 53 == 0)
            stall_style = $urandom_range(0, 3);
        case (stall_style)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= 1'($urandom_range(0, 1));
            2:       rsp_if.ready <= (rcv_cycle % 4) != 3;
            default: rsp_if.ready <= (rcv_cycle % 16) < 3;
        endcase
    end

    task automatic drop_valid();
        if (valid_held)
        begin
            req_if.valid <= 1'b0;
            valid_held = 1'b0;
        end
    endtask

    task automatic issue_req(log_req_t r, bit typed, log_result_t typed_res);
        log_result_t res;
        req_if.valid      <= 1'b1;
        req_if.mode       <= r.mode;
        req_if.stamp      <= r.stamp;
        req_if.error_code <= r.code;
        req_if.channel_id <= r.chan;
        req_if.extra_byte <= r.extra;
        req_if.age_index  <= r.age;
        valid_held = 1'b1;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        res = predict_log_step(r);
        pending_results.push_back(typed ? typed_res : res);
        case (r.mode)
            MODE_LOG:   n_log++;
            MODE_READ:  n_read++;
            MODE_CLEAR: n_clear++;
            default:    n_unused++;
        endcase
        if (res.found)
            n_hit++;
    endtask

    // bursts of back-to-back transactions separated by random gaps
    task automatic pace_sender();
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            drop_valid();
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3))
                @(posedge clk);
        end
    endtask

    task automatic drain_log();
        drop_valid();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic log_req_t random_req();
        log_req_t r;
        int pick;
        r.stamp = $urandom;
        r.code  = 8'($urandom_range(0, 255));
        r.chan  = 8'($urandom_range(0, 255));
        r.extra = 8'($urandom_range(0, 255));
        r.age   = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 48)
            r.mode = MODE_LOG;
        else if (pick < 90)
            r.mode = MODE_READ;
        else if (pick < 96)
            r.mode = MODE_CLEAR;
        else
            r.mode = MODE_UNUSED;
        if (r.mode == MODE_READ)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6 && ring_count > 0)
                r.age = 8'($urandom_range(0, ring_count - 1));
            else if (pick < 8)
                r.age = 8'(ring_count + $urandom_range(0, 2));
        end
        return r;
    endfunction

    initial
    begin
        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.mode       = MODE_LOG;
        req_if.stamp      = '0;
        req_if.error_code = '0;
        req_if.channel_id = '0;
        req_if.extra_byte = '0;
        req_if.age_index  = '0;
        rsp_if.ready      = 1'b0;
        valid_held        = 1'b0;
        error_count       = 0;
        cycle_count       = 0;
        rsp_count         = 0;
        n_log             = 0;
        n_read            = 0;
        n_hit             = 0;
        n_clear           = 0;
        n_unused          = 0;
        burst_left        = 4;
        stall_style       = 0;
        rcv_cycle         = 0;
        ring_head         = 0;
        ring_count        = 0;
        ring_total        = '0;
        foreach (ring_slots[i])
            ring_slots[i] = '0;

        // empty log, extremes, wrap round, unused mode and clear
        directed_rows.push_back('{mk_req(MODE_READ, 32'h0, 8'h0, 8'h0, 8'h0, 8'd0), 1'b1,
                                  mk_res(0, 0, 0, 0, 0, 0, 0, 0, 0)});
        directed_rows.push_back('{mk_req(MODE_UNUSED, '1, '1, '1, '1, '1), 1'b1,
                                  mk_res(0, 0, 0, 0, 0, 0, 0, 0, 0)});
        directed_rows.push_back('{mk_req(MODE_CLEAR, 32'h0, 8'h0, 8'h0, 8'h0, 8'd0), 1'b1,
                                  mk_res(0, 0, 0, 0, 0, 0, 0, 0, 0)});
        directed_rows.push_back('{mk_req(MODE_LOG, '1, '1, '1, '1, 8'd0), 1'b1,
                                  mk_res(0, 0, 0, 0, 0, 1, 8'hff, '1, 1)});
        directed_rows.push_back('{mk_req(MODE_READ, 32'h0, 8'h0, 8'h0, 8'h0, 8'd0), 1'b1,
                                  mk_res(1, '1, '1, '1, '1, 1, 8'hff, '1, 1)});
        directed_rows.push_back('{mk_req(MODE_READ, 32'h0, 8'h0, 8'h0, 8'h0, 8'd1), 1'b1,
                                  mk_res(0, 0, 0, 0, 0, 1, 8'hff, '1, 1)});
        directed_rows.push_back('{mk_req(MODE_LOG, 32'h0, 8'h0, 8'h0, 8'h0, 8'hff), 1'b1,
                                  mk_res(0, 0, 0, 0, 0, 2, 0, 0, 2)});
        directed_rows.push_back('{mk_req(MODE_READ, 32'h0, 8'h0, 8'h0, 8'h0, 8'hff), 1'b1,
                                  mk_res(0, 0, 0, 0, 0, 2, 0, 0, 2)});
        for (int i = 0; i < 7; i++)
            directed_rows.push_back('{mk_req(MODE_LOG, 32'h1000_0000 * (i + 1) + i,
                                             8'(8'h11 * i + 1), 8'(8'h80 >> i),
                                             8'(8'h01 << i), 8'd0), 1'b0, '0});
        directed_rows.push_back('{mk_req(MODE_READ, 32'h0, 8'h0, 8'h0, 8'h0, 8'd0), 1'b0, '0});
        directed_rows.push_back('{mk_req(MODE_READ, 32'h0, 8'h0, 8'h0, 8'h0, 8'd7), 1'b0, '0});
        directed_rows.push_back('{mk_req(MODE_READ, 32'h0, 8'h0, 8'h0, 8'h0, 8'd8), 1'b0, '0});
        directed_rows.push_back('{mk_req(MODE_UNUSED, '1, '1, '1, '1, 8'd3), 1'b0, '0});
        directed_rows.push_back('{mk_req(MODE_CLEAR, '1, '1, '1, '1, 8'd0), 1'b0, '0});
        directed_rows.push_back('{mk_req(MODE_READ, 32'h0, 8'h0, 8'h0, 8'h0, 8'd0), 1'b0, '0});
        directed_rows.push_back('{mk_req(MODE_LOG, 32'h5a5a_a5a5, 8'h5a, 8'ha5, 8'h3c, 8'd0),
                                  1'b0, '0});
        directed_rows.push_back('{mk_req(MODE_READ, 32'h0, 8'h0, 8'h0, 8'h0, 8'd0), 1'b0, '0});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_rows[i])
        begin
            issue_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
            pace_sender();
        end
        drain_log();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            issue_req(random_req(), 1'b0, '0);
            pace_sender();
            if (i == RANDOM_ITEMS / 2)
                drain_log();
        end
        drain_log();
        repeat (20) @(posedge clk);

        $display("sent %0d transactions: %0d logs, %0d reads (%0d hits), %0d clears, %0d unused",
                 n_log + n_read + n_clear + n_unused, n_log, n_read, n_hit, n_clear, n_unused);
        $display("checked %0d responses, %0d mismatches", rsp_count, error_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

>>> overwriting_error_log_ring_top.f
src/elr_pkg.sv
src/elr_in_if.sv
src/elr_out_if.sv
src/elr_ram.sv
src/elr_status.sv
src/overwriting_error_log_ring_top.sv
test/overwriting_error_log_ring_top_test.sv
